### design/tnac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_pkg
// Shared widths, constants and helpers for the triangle normal/area core.
// ----------------------------------------------------------------------------
package tnac_pkg;

   localparam int FIELD_W      = 24;
   localparam int AREA_W       = 48;
   localparam int NORM_W       = 16;
   localparam int DIV_STEPS    = 16;
   localparam int DIV_LAT      = DIV_STEPS + 1;
   localparam int RECIP_SHIFT  = 32;
   localparam int AREA_BASE    = 23;
   localparam int MID_LIMIT    = 1 << (FIELD_W - 1);
   localparam int NORM_NEG_MAG = 32768;
   localparam int NORM_POS_MAX = 32767;

   localparam logic [RECIP_SHIFT-1:0] RECIP3 = 32'h5555_5556;

   typedef logic [AREA_W-1:0]        area_type;
   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic signed [NORM_W-1:0]  norm_type;

   localparam area_type AREA_MAX = '1;

   // Signed width of a coordinate after it has been read from its field.
   function automatic int eff_width(input int coord_bits);
      return (coord_bits <= FIELD_W) ? coord_bits : FIELD_W + 1;
   endfunction

endpackage

### design/triangle_normal_area_centroid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_normal_area_centroid_core
// Unit face normal, area and centroid of one triangle per clock.
// ----------------------------------------------------------------------------
// The bit-per-stage square root makes up most of the pipeline depth.
// Throughput: one request per cycle; busy is never raised.
// Reset clears every valid bit of the pipeline and the area limit register.
// The receiver cannot stall, so every stage advances on every clock.
module triangle_normal_area_centroid_core
   import tnac_pkg::*;
#(
   parameter int COORD_BITS      = 24,
   parameter int COORD_FRAC_BITS = 12
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             csr_write_enable,
   input  area_type         csr_write_data,
   input  field_type        req_corner_a_x,
   input  field_type        req_corner_a_y,
   input  field_type        req_corner_a_z,
   input  field_type        req_corner_b_x,
   input  field_type        req_corner_b_y,
   input  field_type        req_corner_b_z,
   input  field_type        req_corner_c_x,
   input  field_type        req_corner_c_y,
   input  field_type        req_corner_c_z,
   output logic             rsp_valid,
   output norm_type         rsp_unit_normal_x,
   output norm_type         rsp_unit_normal_y,
   output norm_type         rsp_unit_normal_z,
   output area_type         rsp_face_area,
   output field_type        rsp_mid_x,
   output field_type        rsp_mid_y,
   output field_type        rsp_mid_z,
   output logic             rsp_is_degenerate
);

   // Derived widths: EW signed coordinate, MB cross-product magnitude,
   // RB length (square root of the sum of three squares).
   localparam int EW    = eff_width(COORD_BITS);
   localparam int MB    = 2 * EW + 2;
   localparam int RB    = MB + 1;
   localparam int SB    = 3 * MB + 3 + 3 * FIELD_W;
   localparam int LAT   = RB + 24;
   localparam int SHIFT = AREA_BASE - 2 * COORD_FRAC_BITS;
   localparam int XAW   = (RB + AREA_BASE + 1 > AREA_W + 1) ? RB + AREA_BASE + 1
                                                             : AREA_W + 1;

   // The user must write the limit register only while no request is in flight; the block does not enforce it.
   area_type limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // The pipeline takes a request every cycle.
   assign busy = 1'b0;

   logic [2:0][2:0][FIELD_W-1:0] corners;

   assign corners[0][0] = req_corner_a_x;
   assign corners[0][1] = req_corner_a_y;
   assign corners[0][2] = req_corner_a_z;
   assign corners[1][0] = req_corner_b_x;
   assign corners[1][1] = req_corner_b_y;
   assign corners[1][2] = req_corner_b_z;
   assign corners[2][0] = req_corner_c_x;
   assign corners[2][1] = req_corner_c_y;
   assign corners[2][2] = req_corner_c_z;

   // Front end: cross product n = (b - a) x (c - a) split into magnitude and
   // sign, plus the rounded corner mean.
   logic                    cr_valid;
   logic [2:0][MB-1:0]      cr_mag;
   logic [2:0]              cr_neg;
   logic [2:0][FIELD_W-1:0] cr_mid;

   tnac_cross #(
      .COORD_BITS (COORD_BITS),
      .MB         (MB)
   ) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .corner_in (corners),
      .out_valid (cr_valid),
      .mag_out   (cr_mag),
      .neg_out   (cr_neg),
      .mid_out   (cr_mid)
   );

   // Length of n. The cross product components and centroid travel alongside
   // the root as sideband so they line up with it at the far end.
   logic                    sq_valid;
   logic [RB-1:0]           sq_root;
   logic [SB-1:0]           sq_side;
   logic [2:0][MB-1:0]      sq_mag;
   logic [2:0]              sq_neg;
   logic [2:0][FIELD_W-1:0] sq_mid;

   tnac_sqrt #(
      .MB (MB),
      .SB (SB)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cr_valid),
      .mag_in    (cr_mag),
      .side_in   ({cr_mag, cr_neg, cr_mid}),
      .out_valid (sq_valid),
      .root_out  (sq_root),
      .side_out  (sq_side)
   );

   assign sq_mid = sq_side[3*FIELD_W-1:0];
   assign sq_neg = sq_side[3*FIELD_W +: 3];
   assign sq_mag = sq_side[3*FIELD_W+3 +: 3*MB];

   // Area is half the length, rescaled to 24 fraction bits and saturated.
   logic [XAW-1:0] area_wide;
   area_type       area_in;

   if (SHIFT >= 0) begin : g_area_up
      assign area_wide = XAW'(sq_root) << SHIFT;
   end else begin : g_area_down
      assign area_wide = XAW'(sq_root) >> (-SHIFT);
   end

   assign area_in = (area_wide > XAW'(AREA_MAX)) ? AREA_MAX : area_wide[AREA_W-1:0];

   // Three divider lanes, one per normal component.
   norm_type dv_norm [3];

   for (genvar a = 0; a < 3; a++) begin : g_lane
      tnac_div #(
         .MB (MB)
      ) u_div (
         .clock    (clock),
         .mag_in   (sq_mag[a]),
         .neg_in   (sq_neg[a]),
         .len_in   (sq_root),
         .norm_out (dv_norm[a])
      );
   end

   // Area, centroid and valid wait here for the divider lanes.
   logic                    dly_valid_ff [DIV_LAT];
   area_type                dly_area_ff  [DIV_LAT];
   logic [2:0][FIELD_W-1:0] dly_mid_ff   [DIV_LAT];

   always_ff @(posedge clock) begin
      dly_area_ff[0] <= area_in;
      dly_mid_ff[0]  <= sq_mid;
      for (int i = 1; i < DIV_LAT; i++) begin
         dly_area_ff[i] <= dly_area_ff[i-1];
         dly_mid_ff[i]  <= dly_mid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            dly_valid_ff[i] <= 1'b0;
         end
      end else begin
         dly_valid_ff[0] <= sq_valid;
         for (int i = 1; i < DIV_LAT; i++) begin
            dly_valid_ff[i] <= dly_valid_ff[i-1];
         end
      end
   end

   // Output register. A face at or below the limit reports the +z normal.
   logic      valid_ff;
   norm_type  nx_ff, ny_ff, nz_ff;
   area_type  area_ff;
   field_type mx_ff, my_ff, mz_ff;
   logic      degen_ff;
   logic      degen_in;

   assign degen_in = (dly_area_ff[DIV_LAT-1] <= limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dly_valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      degen_ff <= degen_in;
      area_ff  <= dly_area_ff[DIV_LAT-1];
      mx_ff    <= dly_mid_ff[DIV_LAT-1][0];
      my_ff    <= dly_mid_ff[DIV_LAT-1][1];
      mz_ff    <= dly_mid_ff[DIV_LAT-1][2];
      if (degen_in) begin
         nx_ff <= '0;
         ny_ff <= '0;
         nz_ff <= NORM_W'(NORM_POS_MAX);
      end else begin
         nx_ff <= dv_norm[0];
         ny_ff <= dv_norm[1];
         nz_ff <= dv_norm[2];
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_unit_normal_x = nx_ff;
   assign rsp_unit_normal_y = ny_ff;
   assign rsp_unit_normal_z = nz_ff;
   assign rsp_face_area     = area_ff;
   assign rsp_mid_x         = mx_ff;
   assign rsp_mid_y         = my_ff;
   assign rsp_mid_z         = mz_ff;
   assign rsp_is_degenerate = degen_ff;

   // Every response traces back to an earlier request on start.
   a_resp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("response without a matching request");

   // A degenerate face always reports the +z normal.
   a_degen_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_degenerate |->
         rsp_unit_normal_x == '0 && rsp_unit_normal_y == '0 &&
         rsp_unit_normal_z == NORM_W'(NORM_POS_MAX))
      else $error("degenerate face with a non-default normal");

   // A zero area can never exceed the limit.
   a_zero_area_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_degenerate || rsp_face_area != '0)
      else $error("zero area not flagged degenerate");

endmodule

### design/tnac_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_cross
// Edge vectors, cross product and rounded corner mean in three stages.
// ----------------------------------------------------------------------------
module tnac_cross
   import tnac_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int MB         = 50
)
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [2:0][2:0][FIELD_W-1:0]    corner_in,
   output logic                            out_valid,
   output logic [2:0][MB-1:0]              mag_out,
   output logic [2:0]                      neg_out,
   output logic [2:0][FIELD_W-1:0]         mid_out
);

   localparam int EW  = eff_width(COORD_BITS);
   localparam int DW  = EW + 1;
   localparam int PW  = 2 * DW;
   localparam int SMW = EW + 2;
   localparam int QW  = SMW + RECIP_SHIFT;
   localparam int XW  = (SMW > FIELD_W + 1) ? SMW : FIELD_W + 1;

   logic signed [EW-1:0]  crd [3][3];

   logic signed [DW-1:0]  u_ff [3], u_in [3], v_ff [3], v_in [3];
   logic signed [SMW-1:0] sum_ff [3], sum_in [3];
   logic                  v1_ff, v2_ff, v3_ff;

   logic signed [PW-1:0]  p_ff [6], p_in [6];
   logic [QW-1:0]         prod3_ff [3], prod3_in [3];
   logic [2:0]            sneg_ff, sneg_in;

   logic [2:0][MB-1:0]      mag_ff, mag_in;
   logic [2:0]              neg_ff, neg_in;
   logic [2:0][FIELD_W-1:0] mid_ff, mid_in;

   // Coordinates are sign extended from COORD_BITS, or read unsigned when wider.
   for (genvar k = 0; k < 3; k++) begin : g_crd_k
      for (genvar a = 0; a < 3; a++) begin : g_crd_a
         if (COORD_BITS <= FIELD_W) begin : g_signed
            assign crd[k][a] = $signed(corner_in[k][a][EW-1:0]);
         end else begin : g_unsigned
            assign crd[k][a] = $signed({1'b0, corner_in[k][a]});
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         u_in[a]   = DW'(crd[1][a]) - DW'(crd[0][a]);
         v_in[a]   = DW'(crd[2][a]) - DW'(crd[0][a]);
         sum_in[a] = SMW'(crd[0][a]) + SMW'(crd[1][a]) + SMW'(crd[2][a]);
      end
   end

   always_comb begin
      logic [SMW-1:0] smag;
      p_in[0] = PW'(u_ff[1]) * PW'(v_ff[2]);
      p_in[1] = PW'(u_ff[2]) * PW'(v_ff[1]);
      p_in[2] = PW'(u_ff[2]) * PW'(v_ff[0]);
      p_in[3] = PW'(u_ff[0]) * PW'(v_ff[2]);
      p_in[4] = PW'(u_ff[0]) * PW'(v_ff[1]);
      p_in[5] = PW'(u_ff[1]) * PW'(v_ff[0]);
      smag = '0;
      for (int a = 0; a < 3; a++) begin
         smag        = sum_ff[a][SMW-1] ? SMW'(-sum_ff[a]) : SMW'(sum_ff[a]);
         prod3_in[a] = QW'(smag + SMW'(1)) * QW'(RECIP3);
         sneg_in[a]  = sum_ff[a][SMW-1];
      end
   end

   always_comb begin
      logic signed [PW:0] n;
      logic [XW-1:0]      qx;
      n  = '0;
      qx = '0;
      for (int a = 0; a < 3; a++) begin
         n         = (PW+1)'(p_ff[2*a]) - (PW+1)'(p_ff[2*a+1]);
         neg_in[a] = n[PW];
         mag_in[a] = MB'(n[PW] ? -n : n);
         qx        = XW'(prod3_ff[a][QW-1:RECIP_SHIFT]);
         if (sneg_ff[a]) begin
            mid_in[a] = (qx > XW'(MID_LIMIT)) ? FIELD_W'(MID_LIMIT)
                                               : FIELD_W'(XW'(0) - qx);
         end else begin
            mid_in[a] = (qx > XW'(MID_LIMIT - 1)) ? FIELD_W'(MID_LIMIT - 1)
                                                   : FIELD_W'(qx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      v_ff     <= v_in;
      sum_ff   <= sum_in;
      p_ff     <= p_in;
      prod3_ff <= prod3_in;
      sneg_ff  <= sneg_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      mid_ff   <= mid_in;
   end

   assign out_valid = v3_ff;
   assign mag_out   = mag_ff;
   assign neg_out   = neg_ff;
   assign mid_out   = mid_ff;

endmodule

### design/tnac_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_sqrt
// Squared length of the cross product and its pipelined integer square root.
// ----------------------------------------------------------------------------
module tnac_sqrt
   import tnac_pkg::*;
#(
   parameter int MB = 50,
   parameter int SB = 225
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [2:0][MB-1:0]  mag_in,
   input  logic [SB-1:0]       side_in,
   output logic                out_valid,
   output logic [MB:0]         root_out,
   output logic [SB-1:0]       side_out
);

   localparam int RB = MB + 1;
   localparam int SW = 2 * RB;
   localparam int RW = RB + 3;
   localparam int H  = (MB + 1) / 2;
   localparam int HW = MB - H;

   logic [2*HW-1:0] hh_ff [3];
   logic [MB-1:0]   hl_ff [3];
   logic [2*H-1:0]  ll_ff [3];
   logic [2*MB-1:0] sq_ff [3];
   logic            v1_ff, v2_ff;
   logic [SB-1:0]   side1_ff, side2_ff;

   logic [SW-1:0]   rad_ff  [RB+1];
   logic [RW-1:0]   rem_ff  [RB+1];
   logic [RB-1:0]   root_ff [RB+1];
   logic            val_ff  [RB+1];
   logic [SB-1:0]   side_ff [RB+1];

   // Each magnitude is split in halves so that no multiplier exceeds H bits.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         hh_ff[i] <= (2*HW)'(mag_in[i][MB-1:H]) * (2*HW)'(mag_in[i][MB-1:H]);
         hl_ff[i] <= MB'(mag_in[i][MB-1:H]) * MB'(mag_in[i][H-1:0]);
         ll_ff[i] <= (2*H)'(mag_in[i][H-1:0]) * (2*H)'(mag_in[i][H-1:0]);
         sq_ff[i] <= ((2*MB)'(hh_ff[i]) << (2*H)) + ((2*MB)'(hl_ff[i]) << (H+1))
                     + (2*MB)'(ll_ff[i]);
      end
      side1_ff   <= side_in;
      side2_ff   <= side1_ff;
      rad_ff[0]  <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      side_ff[0] <= side2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         val_ff[0] <= 1'b0;
      end else begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         val_ff[0] <= v2_ff;
      end
   end

   // One root bit per stage, most significant first.
   for (genvar k = 0; k < RB; k++) begin : g_step
      logic [RW-1:0] cur, trial, rem_in;
      logic [RB-1:0] root_in;

      always_comb begin
         cur   = {rem_ff[k][RW-3:0], rad_ff[k][SW-1:SW-2]};
         trial = RW'({root_ff[k], 2'b01});
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_ff[k][RB-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_ff[k][RB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k+1]  <= {rad_ff[k][SW-3:0], 2'b00};
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         side_ff[k+1] <= side_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else begin
            val_ff[k+1] <= val_ff[k];
         end
      end
   end

   assign out_valid = val_ff[RB];
   assign root_out  = root_ff[RB];
   assign side_out  = side_ff[RB];

endmodule

### design/tnac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_div
// One normal lane: pipelined restoring division of |n| by the length to Q1.15.
// ----------------------------------------------------------------------------
module tnac_div
   import tnac_pkg::*;
#(
   parameter int MB = 50
)
(
   input  logic           clock,
   input  logic [MB-1:0]  mag_in,
   input  logic           neg_in,
   input  logic [MB:0]    len_in,
   output norm_type       norm_out
);

   localparam int RB = MB + 1;
   localparam int LS = DIV_STEPS - 1;

   logic [RB-1:0]        rem_ff [DIV_STEPS];
   logic [RB-1:0]        len_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS];
   logic                 neg_ff [DIV_STEPS];
   norm_type             norm_ff;

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [RB:0]          cand;
      logic [RB-1:0]        len_cur, rem_in;
      logic [DIV_STEPS-1:0] quo_prev;
      logic                 neg_cur, bit_in;

      if (j == 0) begin : g_first
         // The magnitude never exceeds the length, so the top bit is 0 or 1.
         assign cand     = (RB+1)'(mag_in);
         assign len_cur  = len_in;
         assign quo_prev = '0;
         assign neg_cur  = neg_in;
      end else begin : g_next
         assign cand     = {rem_ff[j-1], 1'b0};
         assign len_cur  = len_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign neg_cur  = neg_ff[j-1];
      end

      always_comb begin
         bit_in = (cand >= (RB+1)'(len_cur));
         rem_in = bit_in ? RB'(cand - (RB+1)'(len_cur)) : RB'(cand);
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         len_ff[j] <= len_cur;
         quo_ff[j] <= {quo_prev[DIV_STEPS-2:0], bit_in};
         neg_ff[j] <= neg_cur;
      end
   end

   always_ff @(posedge clock) begin
      logic [DIV_STEPS:0] qr;
      logic               up;
      up = ({rem_ff[LS], 1'b0} >= (RB+1)'(len_ff[LS]));
      qr = (DIV_STEPS+1)'(quo_ff[LS]) + (DIV_STEPS+1)'(up);
      if (neg_ff[LS]) begin
         if (qr > (DIV_STEPS+1)'(NORM_NEG_MAG)) begin
            qr = (DIV_STEPS+1)'(NORM_NEG_MAG);
         end
         norm_ff <= NORM_W'((DIV_STEPS+1)'(0) - qr);
      end else begin
         if (qr > (DIV_STEPS+1)'(NORM_POS_MAX)) begin
            qr = (DIV_STEPS+1)'(NORM_POS_MAX);
         end
         norm_ff <= NORM_W'(qr);
      end
   end

   assign norm_out = norm_ff;

endmodule
